/* rtl/fwrbm_pkg.sv */
package fwrbm_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT
    } t_state;

    // stored record, number in the top bits
    typedef struct packed {
        logic [15:0] loco_number;
        logic [1:0]  traction_kind;
        logic [2:0]  service_kind;
        logic [7:0]  class_number;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] loco_number;
        logic [1:0]  traction_kind;
        logic [2:0]  service_kind;
        logic [7:0]  class_number;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [6:0]  entry_count;
        logic [15:0] head_number;
        logic [1:0]  head_traction;
        logic [2:0]  head_service;
        logic [7:0]  head_class;
    } t_out;

endpackage

/* rtl/fwrbm_ram.sv */
module fwrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fifo_with_remove_by_match.sv */
// Ordered queue of up to DEPTH locomotive records with delete-by-key. A command
// is transferred when start is high and busy is low; exactly one result follows,
// shown on o_result for a single cycle while o_done is high. The receiver cannot
// stall, so the result must be captured in that cycle. Push and the unused command
// give their result in the cycle after the transfer and leave busy low, so a new
// command can follow at once. Pop and remove walk the stored entries through the
// one read port of the record RAM, one entry per cycle: a pop moves the entries
// behind the head down, a remove searches up to the match and then shifts the
// entries behind it down to close the gap. On an empty queue, pop and remove
// answer in the cycle after the transfer. Head fields read zero when empty.
module fifo_with_remove_by_match
    import fwrbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output logic o_done,
    output t_out o_result
);

    // control
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done,  n_done;
    logic             r_qv,    n_qv;     // RAM read data valid this cycle

    // datapath
    logic [CNT_W-1:0] r_ptr,   n_ptr;    // next address to read
    logic [CNT_W-1:0] r_qpos,  n_qpos;   // position of data on the RAM output
    t_rec             r_key,   n_key;
    t_rec             r_head,  n_head;   // shadow copy of entry 0
    t_out             r_res,   n_res;

    // RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_rec             ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_q;
    t_rec             q_rec;
    t_rec             rec_in;
    logic [CNT_W-1:0] dst_pos;

    function automatic t_out make_result(t_status st, logic [CNT_W-1:0] cnt, t_rec hd);
        t_out res;
        res.status      = st;
        res.entry_count = 7'(cnt);
        if (cnt != '0) begin
            res.head_number   = hd.loco_number;
            res.head_traction = hd.traction_kind;
            res.head_service  = hd.service_kind;
            res.head_class    = hd.class_number;
        end else begin
            res.head_number   = '0;
            res.head_traction = '0;
            res.head_service  = '0;
            res.head_class    = '0;
        end
        return res;
    endfunction

    fwrbm_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign q_rec   = t_rec'(ram_q);
    assign dst_pos = r_qpos - CNT_W'(1);

    always_comb begin
        rec_in.loco_number   = i_cmd.loco_number;
        rec_in.traction_kind = i_cmd.traction_kind;
        rec_in.service_kind  = i_cmd.service_kind;
        rec_in.class_number  = i_cmd.class_number;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_qv      = 1'b0;
        n_ptr     = r_ptr;
        n_qpos    = r_ptr;
        n_key     = r_key;
        n_head    = r_head;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_count[IDX_W-1:0];
        ram_wdata = rec_in;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = rec_in;
                    case (i_cmd.cmd)
                        CMD_PUSH: begin
                            n_done = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_res = make_result(ST_FULL, r_count, r_head);
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (r_count == '0) begin
                                    n_head = rec_in;
                                end
                                n_res = make_result(ST_OK, n_count, n_head);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                                n_res  = make_result(ST_EMPTY, r_count, r_head);
                            end else begin
                                // head goes: shift everything from entry 1 down
                                ram_re    = (r_count > CNT_W'(1));
                                ram_raddr = IDX_W'(1);
                                n_qv      = ram_re;
                                n_qpos    = CNT_W'(1);
                                n_ptr     = CNT_W'(2);
                                n_state   = S_SHIFT;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                                n_res  = make_result(ST_NOMATCH, r_count, r_head);
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_qv      = 1'b1;
                                n_qpos    = '0;
                                n_ptr     = CNT_W'(1);
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = make_result(ST_OK, r_count, r_head);
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // reads stream one ahead; on a match the read already in
                // flight is the first entry to move down
                ram_re = (r_ptr < r_count);
                n_qv   = ram_re;
                n_qpos = r_ptr;
                if (ram_re) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (!r_qv) begin
                    n_done  = 1'b1;
                    n_res   = make_result(ST_NOMATCH, r_count, r_head);
                    n_state = S_IDLE;
                end else if (q_rec == r_key) begin
                    n_state = S_SHIFT;
                end
            end

            S_SHIFT: begin
                ram_re = (r_ptr < r_count);
                n_qv   = ram_re;
                n_qpos = r_ptr;
                if (ram_re) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (r_qv) begin
                    // entry at qpos moves one place towards the head
                    ram_we    = 1'b1;
                    ram_waddr = dst_pos[IDX_W-1:0];
                    ram_wdata = q_rec;
                    if (r_qpos == CNT_W'(1)) begin
                        n_head = q_rec;
                    end
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_done  = 1'b1;
                    n_res   = make_result(ST_OK, n_count, r_head);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_qv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_qv    <= n_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_qpos <= n_qpos;
        r_key  <= n_key;
        r_head <= n_head;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // fill level never exceeds the queue depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // push and the unused command answer in the next cycle without going busy
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.cmd == CMD_PUSH || i_cmd.cmd == CMD_NOP))
        |=> (o_done && !busy))
        else $error("push or idle command gave no result");

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    // search never disturbs the stored entries
    a_search_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !ram_we)
        else $error("RAM write during search");
`endif

endmodule
